// ===== design/psc_pkg.sv =====
`timescale 1ns / 1ps

package psc_pkg;

	localparam int SAMPLE_W        = 12;
	localparam int TAG_W           = 12;
	localparam int OUT_W           = 16;
	localparam int ACC_W           = 48;
	localparam int NUM_COEFFS      = 8;
	localparam int COEFF_IDX_W     = $clog2(NUM_COEFFS);
	localparam int REG_DATA_W      = 64;
	localparam int PADDR_W         = COEFF_IDX_W + 3;
	localparam int IN_DATA_W       = 24;
	localparam int OUT_DATA_W      = 32;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF   = 32;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic                valid;
		logic [SAMPLE_W-1:0] sample;
		logic [TAG_W-1:0]    tag;
	} psc_ctl_t;

endpackage

// ===== design/psc_horner_step.sv =====
`timescale 1ns / 1ps

module psc_horner_step import psc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  psc_ctl_t ctl_in,
	input  acc_t     acc_in,
	input  acc_t     coeff,
	output psc_ctl_t ctl_out,
	output acc_t     acc_out
);

	localparam int PROD_W = ACC_W + SAMPLE_W + 1;
	localparam int SUM_W  = PROD_W + 1;

	psc_ctl_t                  ctl_s1;
	logic signed [PROD_W-1:0]  prod_s1;
	psc_ctl_t                  ctl_s2;
	acc_t                      acc_s2;

	logic signed [PROD_W-1:0]  prod_d;
	logic signed [PROD_W-1:0]  shifted;
	logic signed [SUM_W-1:0]   sum_d;
	logic [SUM_W-ACC_W:0]      sum_hi;
	acc_t                      acc_d;

	assign prod_d = acc_in * $signed({1'b0, ctl_in.sample});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_d;
		end
	end

	// floor division by 2^SAMPLE_BITS, add next coefficient, clamp to accumulator range
	assign shifted = prod_s1 >>> SAMPLE_BITS;
	assign sum_d   = $signed({shifted[PROD_W-1], shifted})
		+ $signed({{(SUM_W-ACC_W){coeff[ACC_W-1]}}, coeff});
	assign sum_hi  = sum_d[SUM_W-1:ACC_W-1];

	always_comb begin
		if ((&sum_hi) || !(|sum_hi)) begin
			acc_d = sum_d[ACC_W-1:0];
		end else if (sum_d[SUM_W-1]) begin
			acc_d = ACC_MIN;
		end else begin
			acc_d = ACC_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s2 <= acc_d;
		end
	end

	assign ctl_out = ctl_s2;
	assign acc_out = acc_s2;

endmodule

// ===== design/polynomial_sensor_correction_top.sv =====
`timescale 1ns / 1ps

// Degree-7 polynomial correction of a raw sensor sample, one request per clock while the
// skid register is empty. Each of the seven Horner steps is a multiply stage and an
// add-and-clamp stage; a rounding stage, a subtract-and-saturate stage and the output
// register follow. New requests enter before earlier ones leave. A two-entry output buffer
// (output register plus skid register) decouples the sides; s_tready drops only once both
// hold results that the consumer has not taken. Coefficients are 48-bit signed values at
// byte address 8*k on the register port and must only be written while the block is empty.

module polynomial_sensor_correction_top import psc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [REG_DATA_W-1:0] pwdata,
	output logic [REG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // raw_sample[11:0], tag[23:12]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // tag_out[11:0], corrected[27:12], zero[31:28]
);

	localparam int MAG_W  = ACC_W - FRAC_BITS + 1;
	localparam int DIFF_W = (MAG_W + 2 > SAMPLE_W + 2) ? MAG_W + 2 : SAMPLE_W + 2;
	localparam int STEPS  = NUM_COEFFS - 1;

	acc_t                  coeff_q [NUM_COEFFS];
	psc_ctl_t              ctl_chain [STEPS+1];
	acc_t                  acc_chain [STEPS+1];
	logic                  adv;

	psc_ctl_t              ctl_s15;
	logic                  neg_s15;
	logic [MAG_W-1:0]      mag_s15;
	psc_ctl_t              ctl_s16;
	logic signed [OUT_W-1:0] corr_s16;

	logic                  out_valid_q;
	logic [TAG_W-1:0]      out_tag_q;
	logic signed [OUT_W-1:0] out_corr_q;
	logic                  skid_valid_q;
	logic [TAG_W-1:0]      skid_tag_q;
	logic signed [OUT_W-1:0] skid_corr_q;

	logic [ACC_W:0]        abs_acc;
	logic [ACC_W:0]        rnd_sum;
	logic signed [DIFF_W-1:0] samp_ext;
	logic signed [DIFF_W-1:0] mag_ext;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-OUT_W:0] diff_hi;
	logic signed [OUT_W-1:0] corr_d;
	logic                  produce;
	logic                  out_free;

	// register port
	assign pready = 1'b1;
	assign prdata = {{(REG_DATA_W-ACC_W){coeff_q[paddr[PADDR_W-1:3]][ACC_W-1]}},
		coeff_q[paddr[PADDR_W-1:3]]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEFFS; k++) begin
				coeff_q[k] <= '0;
			end
		end else if (psel && penable && pwrite && pready) begin
			coeff_q[paddr[PADDR_W-1:3]] <= pwdata[ACC_W-1:0];
		end
	end

	// Horner chain
	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	assign ctl_chain[0].valid  = s_tvalid;
	assign ctl_chain[0].sample = s_tdata[SAMPLE_W-1:0];
	assign ctl_chain[0].tag    = s_tdata[SAMPLE_W+TAG_W-1:SAMPLE_W];
	assign acc_chain[0]        = coeff_q[NUM_COEFFS-1];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		psc_horner_step #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_in (ctl_chain[i]),
			.acc_in (acc_chain[i]),
			.coeff  (coeff_q[NUM_COEFFS-2-i]),
			.ctl_out(ctl_chain[i+1]),
			.acc_out(acc_chain[i+1])
		);
	end

	// round half away from zero
	assign abs_acc = acc_chain[STEPS][ACC_W-1]
		? (ACC_W+1)'(-$signed({acc_chain[STEPS][ACC_W-1], acc_chain[STEPS]}))
		: {1'b0, acc_chain[STEPS]};
	assign rnd_sum = abs_acc + ((ACC_W+1)'(1) << (FRAC_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s15 <= '0;
		end else if (adv) begin
			ctl_s15 <= ctl_chain[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s15 <= acc_chain[STEPS][ACC_W-1];
			mag_s15 <= rnd_sum[ACC_W:FRAC_BITS];
		end
	end

	// subtract and saturate
	assign samp_ext = $signed({{(DIFF_W-SAMPLE_W){1'b0}}, ctl_s15.sample});
	assign mag_ext  = $signed({{(DIFF_W-MAG_W){1'b0}}, mag_s15});
	assign diff     = neg_s15 ? samp_ext + mag_ext : samp_ext - mag_ext;
	assign diff_hi  = diff[DIFF_W-1:OUT_W-1];

	always_comb begin
		if ((&diff_hi) || !(|diff_hi)) begin
			corr_d = diff[OUT_W-1:0];
		end else if (diff[DIFF_W-1]) begin
			corr_d = OUT_MIN;
		end else begin
			corr_d = OUT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s16 <= '0;
		end else if (adv) begin
			ctl_s16 <= ctl_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			corr_s16 <= corr_d;
		end
	end

	// output register and skid register
	assign produce  = adv && ctl_s16.valid;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_tag_q  <= skid_tag_q;
				out_corr_q <= skid_corr_q;
			end else begin
				out_tag_q  <= ctl_s16.tag;
				out_corr_q <= corr_s16;
			end
		end else if (produce) begin
			skid_tag_q  <= ctl_s16.tag;
			skid_corr_q <= corr_s16;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-OUT_W-TAG_W){1'b0}}, out_corr_q, out_tag_q};

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready && ctl_s16.valid))
		else $error("skid register filled without a stalled output");

	a_out_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(m_tready) && !skid_valid_q)
		else $error("output result dropped without being taken");
`endif

endmodule
